>>> rtl/core/ptds_pkg.sv
// Shared types and constants for the point-to-triangle squared distance unit.
// No dependencies.
`default_nettype none

package ptds_pkg;

	localparam int FIELD_BITS = 16;
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIST_BITS = 50;

	typedef enum logic [2:0] {
		RG_VERT_A  = 3'd0,
		RG_VERT_B  = 3'd1,
		RG_EDGE_AB = 3'd2,
		RG_VERT_C  = 3'd3,
		RG_EDGE_AC = 3'd4,
		RG_EDGE_BC = 3'd5,
		RG_FACE    = 3'd6,
		RG_DEGEN   = 3'd7
	} region_t;

	typedef struct packed {
		logic    sat;
		region_t region;
	} ptds_tag_t;

endpackage

`default_nettype wire

>>> rtl/core/ptds_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the distance unit.
// Depends on ptds_pkg.
`default_nettype none

module ptds_div
	import ptds_pkg::*;
#(
	parameter int DEN_BITS = 4 * COORD_BITS_DEF + 8,
	parameter int QUO_BITS = DIST_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [DEN_BITS+QUO_BITS-1:0]   in_rem,
	input  wire logic [DEN_BITS-1:0]            in_den,
	input  wire ptds_tag_t                      in_tag,
	output logic                                out_valid,
	output logic [QUO_BITS-1:0]                 out_q,
	output ptds_tag_t                           out_tag
);

	localparam int REMW = DEN_BITS + QUO_BITS;

	logic [REMW-1:0]     rem_in [QUO_BITS];
	logic [DEN_BITS-1:0] den_in [QUO_BITS];
	logic [QUO_BITS-1:0] q_in   [QUO_BITS];
	ptds_tag_t           tag_in [QUO_BITS];
	logic [REMW-1:0]     trial  [QUO_BITS];
	logic [QUO_BITS-1:0] ge;

	logic [REMW-1:0]     rem_s [QUO_BITS-1];
	logic [DEN_BITS-1:0] den_s [QUO_BITS-1];
	logic [QUO_BITS-1:0] q_s   [QUO_BITS];
	ptds_tag_t           tag_s [QUO_BITS];
	logic [QUO_BITS-1:0] vld_s;

	always_comb begin
		rem_in[0] = in_rem;
		den_in[0] = in_den;
		q_in[0]   = '0;
		tag_in[0] = in_tag;
		for (int j = 1; j < QUO_BITS; j++) begin
			rem_in[j] = rem_s[j-1];
			den_in[j] = den_s[j-1];
			q_in[j]   = q_s[j-1];
			tag_in[j] = tag_s[j-1];
		end
		for (int j = 0; j < QUO_BITS; j++) begin
			trial[j] = REMW'(den_in[j]) << (QUO_BITS - 1 - j);
			ge[j]    = rem_in[j] >= trial[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QUO_BITS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < QUO_BITS; j++) begin
			q_s[j]   <= {q_in[j][QUO_BITS-2:0], ge[j]};
			tag_s[j] <= tag_in[j];
		end
		for (int j = 0; j < QUO_BITS - 1; j++) begin
			rem_s[j] <= ge[j] ? (rem_in[j] - trial[j]) : rem_in[j];
			den_s[j] <= den_in[j];
		end
	end

	assign out_valid = vld_s[QUO_BITS-1];
	assign out_q     = q_s[QUO_BITS-1];
	assign out_tag   = tag_s[QUO_BITS-1];

endmodule

`default_nettype wire

>>> rtl/core/point_triangle_distance_sq_unit.sv
// Top level of the point-to-triangle squared distance unit.
// Depends on ptds_pkg and ptds_div.
`default_nettype none

// Takes one request per clock: a query point and three vertices. busy is always low, and
// the result appears on dist_squared and region with done high once the request has passed
// through every stage below; the receiver cannot stall. Nine front stages form the dot
// products, region tests and the numerator and denominator; the remaining 50 stages are a
// restoring divider that settles one quotient bit per stage.
module point_triangle_distance_sq_unit
	import ptds_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [FIELD_BITS-1:0] query_x,
	input  wire logic [FIELD_BITS-1:0] query_y,
	input  wire logic [FIELD_BITS-1:0] query_z,
	input  wire logic [FIELD_BITS-1:0] first_x,
	input  wire logic [FIELD_BITS-1:0] first_y,
	input  wire logic [FIELD_BITS-1:0] first_z,
	input  wire logic [FIELD_BITS-1:0] second_x,
	input  wire logic [FIELD_BITS-1:0] second_y,
	input  wire logic [FIELD_BITS-1:0] second_z,
	input  wire logic [FIELD_BITS-1:0] third_x,
	input  wire logic [FIELD_BITS-1:0] third_y,
	input  wire logic [FIELD_BITS-1:0] third_z,
	output logic                       done,
	output logic [DIST_BITS-1:0]       dist_squared,
	output logic [2:0]                 region
);

	localparam int CB   = COORD_BITS;
	localparam int FB   = FRAC_BITS;
	localparam int QW   = DIST_BITS;
	localparam int IW   = FIELD_BITS;
	localparam int MX   = (CB > IW) ? CB : IW;
	localparam int VW   = CB + 1;
	localparam int DW   = 2 * CB + 3;
	localparam int H    = DW / 2;
	localparam int PW   = 2 * DW;
	localparam int ZW   = DW + VW + 2;
	localparam int HZ   = ZW / 2;
	localparam int Z2W  = 2 * ZW;
	localparam int XYW  = 2 * DW;
	localparam int NUMW = Z2W;
	localparam int DENW = 2 * DW + 2;
	localparam int REMW = DENW + QW;
	localparam int CW   = ((NUMW + FB) > REMW) ? (NUMW + FB) : REMW;
	localparam int LAT  = 9 + QW;

	typedef struct packed {
		logic signed [DW-1:0] d1;
		logic signed [DW-1:0] d2;
		logic signed [DW-1:0] d7;
		logic signed [DW-1:0] ppa;
		logic signed [DW-1:0] ppb;
		logic signed [DW-1:0] ppc;
		logic signed [DW-1:0] pmin;
		logic signed [DW-1:0] eab;
		logic signed [DW-1:0] eac;
		logic signed [DW-1:0] ebc;
		logic signed [ZW-1:0] napp;
		logic                 c1;
		logic                 c2;
		logic                 c3;
		logic                 c4;
		logic                 c5;
		logic                 c6;
		logic                 nzero;
	} carry_t;

	function automatic logic signed [VW-1:0] sx(input logic [IW-1:0] v);
		logic [MX-1:0] e;
		logic [CB-1:0] t;
		e = MX'(v);
		t = e[CB-1:0];
		return $signed({t[CB-1], t});
	endfunction

	function automatic logic signed [DW-1:0] dot3(
		input logic signed [VW-1:0] u0, u1, u2, v0, v1, v2);
		logic signed [DW-1:0] a0, a1, a2, b0, b1, b2;
		a0 = DW'(u0);
		a1 = DW'(u1);
		a2 = DW'(u2);
		b0 = DW'(v0);
		b1 = DW'(v1);
		b2 = DW'(v2);
		return a0 * b0 + a1 * b1 + a2 * b2;
	endfunction

	function automatic logic signed [DW-1:0] crs(input logic signed [VW-1:0] a, b, c, d);
		logic signed [DW-1:0] ae, be, ce, de;
		ae = DW'(a);
		be = DW'(b);
		ce = DW'(c);
		de = DW'(d);
		return ae * be - ce * de;
	endfunction

	function automatic logic signed [ZW-1:0] dotz(
		input logic signed [DW-1:0] n0, n1, n2,
		input logic signed [VW-1:0] v0, v1, v2);
		logic signed [ZW-1:0] a0, a1, a2, b0, b1, b2;
		a0 = ZW'(n0);
		a1 = ZW'(n1);
		a2 = ZW'(n2);
		b0 = ZW'(v0);
		b1 = ZW'(v1);
		b2 = ZW'(v2);
		return a0 * b0 + a1 * b1 + a2 * b2;
	endfunction

	function automatic logic signed [PW-1:0] mul_lo(input logic signed [DW-1:0] a, b);
		logic signed [PW-1:0] ae, be;
		ae = PW'(a);
		be = $signed(PW'(b[H-1:0]));
		return ae * be;
	endfunction

	function automatic logic signed [PW-1:0] mul_hi(input logic signed [DW-1:0] a, b);
		logic signed [PW-1:0] ae, be;
		ae = PW'(a);
		be = PW'($signed(b[DW-1:H]));
		return ae * be;
	endfunction

	logic accept;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [VW-1:0] ab_s1 [3];
	logic signed [VW-1:0] ac_s1 [3];
	logic signed [VW-1:0] bc_s1 [3];
	logic signed [VW-1:0] ap_s1 [3];
	logic signed [VW-1:0] bp_s1 [3];
	logic signed [VW-1:0] cp_s1 [3];
	logic signed [VW-1:0] pt_q [3];
	logic signed [VW-1:0] va_q [3];
	logic signed [VW-1:0] vb_q [3];
	logic signed [VW-1:0] vc_q [3];

	logic signed [DW-1:0] d1_s2, d2_s2, d3_s2, d4_s2, d5_s2, d6_s2, d7_s2;
	logic signed [DW-1:0] ppa_s2, ppb_s2, ppc_s2, eab_s2, eac_s2, ebc_s2;
	logic signed [DW-1:0] n_s2 [3];
	logic signed [VW-1:0] ap_s2 [3];

	logic signed [PW-1:0] pq_lo_s3 [6];
	logic signed [PW-1:0] pq_hi_s3 [6];
	logic signed [PW-1:0] nsq_lo_s3 [3];
	logic signed [PW-1:0] nsq_hi_s3 [3];
	carry_t               cr_s3;

	logic signed [PW-1:0] pq_s4 [6];
	logic signed [PW-1:0] nsq_s4 [3];
	carry_t               cr_s4;

	logic [DW-1:0]        x_s5, y_s5;
	logic signed [ZW-1:0] z_s5;
	logic [DENW-1:0]      den_s5;
	logic                 face_s5;
	region_t              rg_s5;

	logic [XYW-1:0]       xyl_s6, xyh_s6;
	logic [Z2W-1:0]       zhh_s6, zhl_s6, zll_s6;
	logic [DENW-1:0]      den_s6;
	logic                 face_s6;
	region_t              rg_s6;

	logic [XYW-1:0]       xy_s7;
	logic [Z2W-1:0]       z2_s7;
	logic [DENW-1:0]      den_s7;
	logic                 face_s7;
	region_t              rg_s7;

	logic [NUMW-1:0]      num_s8;
	logic [DENW-1:0]      den_s8;
	region_t              rg_s8;

	logic [REMW-1:0]      rem_s9;
	logic [DENW-1:0]      den_s9;
	ptds_tag_t            tag_s9;

	logic                 le_ab, le_ac, le_bc, edge_sel;
	logic [DENW-1:0]      nn;
	logic signed [DW-1:0] ee_sel;
	logic [DW-1:0]        x_c, y_c;
	logic signed [ZW-1:0] z_c;
	logic [DENW-1:0]      den_c;
	logic                 face_c;
	region_t              rg_c;
	logic [ZW-1:0]        mz;
	logic [CW-1:0]        wide_num, wide_lim;

	logic                 div_valid;
	logic [QW-1:0]        div_q;
	ptds_tag_t            div_tag;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		pt_q[0] = sx(query_x);
		pt_q[1] = sx(query_y);
		pt_q[2] = sx(query_z);
		va_q[0] = sx(first_x);
		va_q[1] = sx(first_y);
		va_q[2] = sx(first_z);
		vb_q[0] = sx(second_x);
		vb_q[1] = sx(second_y);
		vb_q[2] = sx(second_z);
		vc_q[0] = sx(third_x);
		vc_q[1] = sx(third_y);
		vc_q[2] = sx(third_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ab_s1[k] <= vb_q[k] - va_q[k];
			ac_s1[k] <= vc_q[k] - va_q[k];
			bc_s1[k] <= vc_q[k] - vb_q[k];
			ap_s1[k] <= pt_q[k] - va_q[k];
			bp_s1[k] <= pt_q[k] - vb_q[k];
			cp_s1[k] <= pt_q[k] - vc_q[k];
		end
	end

	always_ff @(posedge clk) begin
		d1_s2  <= dot3(ab_s1[0], ab_s1[1], ab_s1[2], ap_s1[0], ap_s1[1], ap_s1[2]);
		d2_s2  <= dot3(ac_s1[0], ac_s1[1], ac_s1[2], ap_s1[0], ap_s1[1], ap_s1[2]);
		d3_s2  <= dot3(ab_s1[0], ab_s1[1], ab_s1[2], bp_s1[0], bp_s1[1], bp_s1[2]);
		d4_s2  <= dot3(ac_s1[0], ac_s1[1], ac_s1[2], bp_s1[0], bp_s1[1], bp_s1[2]);
		d5_s2  <= dot3(ab_s1[0], ab_s1[1], ab_s1[2], cp_s1[0], cp_s1[1], cp_s1[2]);
		d6_s2  <= dot3(ac_s1[0], ac_s1[1], ac_s1[2], cp_s1[0], cp_s1[1], cp_s1[2]);
		d7_s2  <= dot3(bc_s1[0], bc_s1[1], bc_s1[2], bp_s1[0], bp_s1[1], bp_s1[2]);
		ppa_s2 <= dot3(ap_s1[0], ap_s1[1], ap_s1[2], ap_s1[0], ap_s1[1], ap_s1[2]);
		ppb_s2 <= dot3(bp_s1[0], bp_s1[1], bp_s1[2], bp_s1[0], bp_s1[1], bp_s1[2]);
		ppc_s2 <= dot3(cp_s1[0], cp_s1[1], cp_s1[2], cp_s1[0], cp_s1[1], cp_s1[2]);
		eab_s2 <= dot3(ab_s1[0], ab_s1[1], ab_s1[2], ab_s1[0], ab_s1[1], ab_s1[2]);
		eac_s2 <= dot3(ac_s1[0], ac_s1[1], ac_s1[2], ac_s1[0], ac_s1[1], ac_s1[2]);
		ebc_s2 <= dot3(bc_s1[0], bc_s1[1], bc_s1[2], bc_s1[0], bc_s1[1], bc_s1[2]);
		n_s2[0] <= crs(ab_s1[1], ac_s1[2], ab_s1[2], ac_s1[1]);
		n_s2[1] <= crs(ab_s1[2], ac_s1[0], ab_s1[0], ac_s1[2]);
		n_s2[2] <= crs(ab_s1[0], ac_s1[1], ab_s1[1], ac_s1[0]);
		for (int k = 0; k < 3; k++) begin
			ap_s2[k] <= ap_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		pq_lo_s3[0] <= mul_lo(d1_s2, d4_s2);
		pq_hi_s3[0] <= mul_hi(d1_s2, d4_s2);
		pq_lo_s3[1] <= mul_lo(d3_s2, d2_s2);
		pq_hi_s3[1] <= mul_hi(d3_s2, d2_s2);
		pq_lo_s3[2] <= mul_lo(d5_s2, d2_s2);
		pq_hi_s3[2] <= mul_hi(d5_s2, d2_s2);
		pq_lo_s3[3] <= mul_lo(d1_s2, d6_s2);
		pq_hi_s3[3] <= mul_hi(d1_s2, d6_s2);
		pq_lo_s3[4] <= mul_lo(d3_s2, d6_s2);
		pq_hi_s3[4] <= mul_hi(d3_s2, d6_s2);
		pq_lo_s3[5] <= mul_lo(d5_s2, d4_s2);
		pq_hi_s3[5] <= mul_hi(d5_s2, d4_s2);
		for (int k = 0; k < 3; k++) begin
			nsq_lo_s3[k] <= mul_lo(n_s2[k], n_s2[k]);
			nsq_hi_s3[k] <= mul_hi(n_s2[k], n_s2[k]);
		end
		cr_s3.d1    <= d1_s2;
		cr_s3.d2    <= d2_s2;
		cr_s3.d7    <= d7_s2;
		cr_s3.ppa   <= ppa_s2;
		cr_s3.ppb   <= ppb_s2;
		cr_s3.ppc   <= ppc_s2;
		if (ppc_s2 < ((ppb_s2 < ppa_s2) ? ppb_s2 : ppa_s2)) begin
			cr_s3.pmin <= ppc_s2;
		end else begin
			cr_s3.pmin <= (ppb_s2 < ppa_s2) ? ppb_s2 : ppa_s2;
		end
		cr_s3.eab   <= eab_s2;
		cr_s3.eac   <= eac_s2;
		cr_s3.ebc   <= ebc_s2;
		cr_s3.napp  <= dotz(n_s2[0], n_s2[1], n_s2[2], ap_s2[0], ap_s2[1], ap_s2[2]);
		cr_s3.c1    <= (d1_s2 <= 0) && (d2_s2 <= 0);
		cr_s3.c2    <= (d3_s2 >= 0) && (d4_s2 <= d3_s2);
		cr_s3.c3    <= (d1_s2 >= 0) && (d3_s2 <= 0);
		cr_s3.c4    <= (d6_s2 >= 0) && (d5_s2 <= d6_s2);
		cr_s3.c5    <= (d2_s2 >= 0) && (d6_s2 <= 0);
		cr_s3.c6    <= (d4_s2 >= d3_s2) && (d5_s2 >= d6_s2);
		cr_s3.nzero <= (n_s2[0] == 0) && (n_s2[1] == 0) && (n_s2[2] == 0);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 6; k++) begin
			pq_s4[k] <= pq_lo_s3[k] + (pq_hi_s3[k] <<< H);
		end
		for (int k = 0; k < 3; k++) begin
			nsq_s4[k] <= nsq_lo_s3[k] + (nsq_hi_s3[k] <<< H);
		end
		cr_s4 <= cr_s3;
	end

	always_comb begin
		nn = DENW'($unsigned(nsq_s4[0])) + DENW'($unsigned(nsq_s4[1]))
			+ DENW'($unsigned(nsq_s4[2]));
		le_ab = pq_s4[0] <= pq_s4[1];
		le_ac = pq_s4[2] <= pq_s4[3];
		le_bc = pq_s4[4] <= pq_s4[5];
		edge_sel = 1'b0;
		ee_sel = '0;
		face_c = 1'b0;
		x_c = '0;
		y_c = DW'(1);
		z_c = '0;
		den_c = DENW'(1);
		rg_c = RG_FACE;
		if (cr_s4.c1) begin
			rg_c = RG_VERT_A;
			x_c = $unsigned(cr_s4.ppa);
		end else if (cr_s4.c2) begin
			rg_c = RG_VERT_B;
			x_c = $unsigned(cr_s4.ppb);
		end else if (le_ab && cr_s4.c3) begin
			rg_c = RG_EDGE_AB;
			edge_sel = 1'b1;
			x_c = $unsigned(cr_s4.ppa);
			ee_sel = cr_s4.eab;
			z_c = ZW'(cr_s4.d1);
		end else if (cr_s4.c4) begin
			rg_c = RG_VERT_C;
			x_c = $unsigned(cr_s4.ppc);
		end else if (le_ac && cr_s4.c5) begin
			rg_c = RG_EDGE_AC;
			edge_sel = 1'b1;
			x_c = $unsigned(cr_s4.ppa);
			ee_sel = cr_s4.eac;
			z_c = ZW'(cr_s4.d2);
		end else if (le_bc && cr_s4.c6) begin
			rg_c = RG_EDGE_BC;
			edge_sel = 1'b1;
			x_c = $unsigned(cr_s4.ppb);
			ee_sel = cr_s4.ebc;
			z_c = ZW'(cr_s4.d7);
		end else if (cr_s4.nzero) begin
			rg_c = RG_DEGEN;
			x_c = $unsigned(cr_s4.pmin);
		end else begin
			rg_c = RG_FACE;
			face_c = 1'b1;
			y_c = '0;
			z_c = cr_s4.napp;
			den_c = nn;
		end
		// A collapsed edge falls back to the distance to its first endpoint.
		if (edge_sel) begin
			if (ee_sel != 0) begin
				y_c = $unsigned(ee_sel);
				den_c = DENW'($unsigned(ee_sel));
			end else begin
				z_c = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s5    <= x_c;
		y_s5    <= y_c;
		z_s5    <= z_c;
		den_s5  <= den_c;
		face_s5 <= face_c;
		rg_s5   <= rg_c;
	end

	assign mz = z_s5[ZW-1] ? $unsigned(-z_s5) : $unsigned(z_s5);

	always_ff @(posedge clk) begin
		xyl_s6  <= XYW'(x_s5) * XYW'(y_s5[H-1:0]);
		xyh_s6  <= XYW'(x_s5) * XYW'(y_s5[DW-1:H]);
		zhh_s6  <= Z2W'(mz[ZW-1:HZ]) * Z2W'(mz[ZW-1:HZ]);
		zhl_s6  <= Z2W'(mz[ZW-1:HZ]) * Z2W'(mz[HZ-1:0]);
		zll_s6  <= Z2W'(mz[HZ-1:0]) * Z2W'(mz[HZ-1:0]);
		den_s6  <= den_s5;
		face_s6 <= face_s5;
		rg_s6   <= rg_s5;
	end

	always_ff @(posedge clk) begin
		xy_s7   <= xyl_s6 + (xyh_s6 << H);
		z2_s7   <= (zhh_s6 << (2 * HZ)) + (zhl_s6 << (HZ + 1)) + zll_s6;
		den_s7  <= den_s6;
		face_s7 <= face_s6;
		rg_s7   <= rg_s6;
	end

	always_ff @(posedge clk) begin
		num_s8 <= face_s7 ? z2_s7 : (NUMW'(xy_s7) - z2_s7);
		den_s8 <= den_s7;
		rg_s8  <= rg_s7;
	end

	always_comb begin
		wide_num = CW'(num_s8) << FB;
		wide_lim = CW'(den_s8) << QW;
	end

	always_ff @(posedge clk) begin
		rem_s9        <= wide_num[REMW-1:0];
		den_s9        <= den_s8;
		tag_s9.sat    <= wide_num >= wide_lim;
		tag_s9.region <= rg_s8;
	end

	ptds_div #(
		.DEN_BITS (DENW),
		.QUO_BITS (QW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.in_rem    (rem_s9),
		.in_den    (den_s9),
		.in_tag    (tag_s9),
		.out_valid (div_valid),
		.out_q     (div_q),
		.out_tag   (div_tag)
	);

	assign done         = div_valid;
	assign dist_squared = div_tag.sat ? '1 : div_q;
	assign region       = div_tag.region;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request did not complete after the pipeline latency");

	a_face_den: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && rg_s5 == RG_FACE) |-> (den_s5 != 0))
		else $error("face region selected with a zero normal");

	a_vert_den: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && (rg_s5 == RG_VERT_A || rg_s5 == RG_VERT_B || rg_s5 == RG_VERT_C
		|| rg_s5 == RG_DEGEN)) |-> (den_s5 == DENW'(1) && z_s5 == 0))
		else $error("vertex region carries an edge or face divisor");

endmodule

`default_nettype wire

>>> bench/ptds_checker.sv
// Checker for the point-to-triangle squared distance unit: it watches requests and results,
// predicts each result and compares. Depends on ptds_pkg.
`timescale 1ns / 1ps

module ptds_checker
	import ptds_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic [FIELD_BITS-1:0] query_x,
	input  wire logic [FIELD_BITS-1:0] query_y,
	input  wire logic [FIELD_BITS-1:0] query_z,
	input  wire logic [FIELD_BITS-1:0] first_x,
	input  wire logic [FIELD_BITS-1:0] first_y,
	input  wire logic [FIELD_BITS-1:0] first_z,
	input  wire logic [FIELD_BITS-1:0] second_x,
	input  wire logic [FIELD_BITS-1:0] second_y,
	input  wire logic [FIELD_BITS-1:0] second_z,
	input  wire logic [FIELD_BITS-1:0] third_x,
	input  wire logic [FIELD_BITS-1:0] third_y,
	input  wire logic [FIELD_BITS-1:0] third_z,
	input  wire logic                  done,
	input  wire logic [DIST_BITS-1:0]  dist_squared,
	input  wire logic [2:0]            region,
	output int                         failures,
	output int                         pending,
	output int                         checked
);

	typedef longint vec3_t [3];
	typedef logic [159:0] wide_t;

	typedef struct {
		logic [DIST_BITS-1:0] sq_dist;
		region_t              rg;
	} distance_t;

	distance_t expected_distances[$];
	int        region_hits[8];

	function automatic longint coord(input logic [FIELD_BITS-1:0] v);
		return longint'($signed(v[COORD_BITS_DEF-1:0]));
	endfunction

	function automatic longint dot3(input vec3_t u, input vec3_t v);
		return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
	endfunction

	function automatic wide_t square(input longint v);
		wide_t m;
		m = wide_t'(v < 0 ? -v : v);
		return m * m;
	endfunction

	function automatic logic [DIST_BITS-1:0] scaled_quotient(input wide_t num, input wide_t den);
		wide_t q;
		q = (num << FRAC_BITS_DEF) / den;
		if (q >= (wide_t'(1) << DIST_BITS))
			return {DIST_BITS{1'b1}};
		return q[DIST_BITS-1:0];
	endfunction

	function automatic logic [DIST_BITS-1:0] point_dist(input longint len2);
		return scaled_quotient(wide_t'(len2), wide_t'(1));
	endfunction

	function automatic logic [DIST_BITS-1:0] line_dist(input vec3_t pv, input vec3_t e,
			input longint proj);
		longint pp;
		longint ee;
		pp = dot3(pv, pv);
		ee = dot3(e, e);
		if (ee == 0)
			return point_dist(pp);
		return scaled_quotient(wide_t'(pp) * wide_t'(ee) - square(proj), wide_t'(ee));
	endfunction

	function automatic bit prod_le(input longint a, input longint b, input longint c,
			input longint d);
		logic signed [159:0] l;
		logic signed [159:0] r;
		l = 160'(a);
		l = l * 160'(b);
		r = 160'(c);
		r = r * 160'(d);
		return l <= r;
	endfunction

	function automatic distance_t predict_distance(input vec3_t p, input vec3_t a,
			input vec3_t b, input vec3_t c);
		vec3_t ab, ac, bc, ap, bp, cp, n;
		longint d1, d2, d3, d4, d5, d6, m;
		wide_t nn;
		distance_t r;
		for (int i = 0; i < 3; i++) begin
			ab[i] = b[i] - a[i];
			ac[i] = c[i] - a[i];
			bc[i] = c[i] - b[i];
			ap[i] = p[i] - a[i];
			bp[i] = p[i] - b[i];
			cp[i] = p[i] - c[i];
		end
		d1 = dot3(ab, ap);
		d2 = dot3(ac, ap);
		d3 = dot3(ab, bp);
		d4 = dot3(ac, bp);
		d5 = dot3(ab, cp);
		d6 = dot3(ac, cp);
		if (d1 <= 0 && d2 <= 0) begin
			r.rg = RG_VERT_A;
			r.sq_dist = point_dist(dot3(ap, ap));
		end else if (d3 >= 0 && d4 <= d3) begin
			r.rg = RG_VERT_B;
			r.sq_dist = point_dist(dot3(bp, bp));
		end else if (prod_le(d1, d4, d3, d2) && d1 >= 0 && d3 <= 0) begin
			r.rg = RG_EDGE_AB;
			r.sq_dist = line_dist(ap, ab, d1);
		end else if (d6 >= 0 && d5 <= d6) begin
			r.rg = RG_VERT_C;
			r.sq_dist = point_dist(dot3(cp, cp));
		end else if (prod_le(d5, d2, d1, d6) && d2 >= 0 && d6 <= 0) begin
			r.rg = RG_EDGE_AC;
			r.sq_dist = line_dist(ap, ac, d2);
		end else if (prod_le(d3, d6, d5, d4) && d4 - d3 >= 0 && d5 - d6 >= 0) begin
			r.rg = RG_EDGE_BC;
			r.sq_dist = line_dist(bp, bc, dot3(bc, bp));
		end else begin
			n[0] = ab[1] * ac[2] - ab[2] * ac[1];
			n[1] = ab[2] * ac[0] - ab[0] * ac[2];
			n[2] = ab[0] * ac[1] - ab[1] * ac[0];
			nn = square(n[0]) + square(n[1]) + square(n[2]);
			if (nn == 0) begin
				m = dot3(ap, ap);
				if (dot3(bp, bp) < m)
					m = dot3(bp, bp);
				if (dot3(cp, cp) < m)
					m = dot3(cp, cp);
				r.rg = RG_DEGEN;
				r.sq_dist = point_dist(m);
			end else begin
				r.rg = RG_FACE;
				r.sq_dist = scaled_quotient(square(dot3(n, ap)), nn);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		failures++;
	endtask

	initial begin
		failures = 0;
		checked = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		vec3_t p, a, b, c;
		distance_t e;
		if (arst_n && start && !busy) begin
			p = '{coord(query_x), coord(query_y), coord(query_z)};
			a = '{coord(first_x), coord(first_y), coord(first_z)};
			b = '{coord(second_x), coord(second_y), coord(second_z)};
			c = '{coord(third_x), coord(third_y), coord(third_z)};
			expected_distances.push_back(predict_distance(p, a, b, c));
		end
		if (arst_n && done) begin
			if (expected_distances.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				e = expected_distances.pop_front();
				checked++;
				region_hits[e.rg]++;
				if (region !== e.rg)
					report_mismatch($sformatf("region %0d, expected %0d", region, e.rg));
				if (dist_squared !== e.sq_dist)
					report_mismatch($sformatf("dist_squared %0h, expected %0h",
						dist_squared, e.sq_dist));
			end
		end
		pending = expected_distances.size();
	end

endmodule

>>> bench/tb_top.sv
// Top of the testbench for point_triangle_distance_sq_unit: makes requests and gives the
// verdict. Depends on ptds_pkg, the unit and ptds_checker.
`timescale 1ns / 1ps

module tb_top
	import ptds_pkg::*;
();

	localparam int RANDOM_REQUESTS = 1530;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [FIELD_BITS-1:0] coords [12];
	logic busy, done;
	logic [DIST_BITS-1:0] dist_squared;
	logic [2:0] region;
	int failures, pending, checked;
	int cycles = 0;
	int sent = 0;
	bit quiet_tail = 1'b0;

	initial
		for (int i = 0; i < 12; i++)
			coords[i] = '0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	point_triangle_distance_sq_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.query_x(coords[0]), .query_y(coords[1]), .query_z(coords[2]),
		.first_x(coords[3]), .first_y(coords[4]), .first_z(coords[5]),
		.second_x(coords[6]), .second_y(coords[7]), .second_z(coords[8]),
		.third_x(coords[9]), .third_y(coords[10]), .third_z(coords[11]),
		.done(done), .dist_squared(dist_squared), .region(region)
	);

	ptds_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.query_x(coords[0]), .query_y(coords[1]), .query_z(coords[2]),
		.first_x(coords[3]), .first_y(coords[4]), .first_z(coords[5]),
		.second_x(coords[6]), .second_y(coords[7]), .second_z(coords[8]),
		.third_x(coords[9]), .third_y(coords[10]), .third_z(coords[11]),
		.done(done), .dist_squared(dist_squared), .region(region),
		.failures(failures), .pending(pending), .checked(checked)
	);

	// Issues one request; start stays high into the next request unless a gap follows.
	task automatic send_request(input logic [FIELD_BITS-1:0] v [12]);
		int gap;
		for (int i = 0; i < 12; i++)
			coords[i] <= v[i];
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sent++;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_points(input int px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz);
		logic [FIELD_BITS-1:0] v [12];
		v = '{px[15:0], py[15:0], pz[15:0], ax[15:0], ay[15:0], az[15:0],
			bx[15:0], by[15:0], bz[15:0], cx[15:0], cy[15:0], cz[15:0]};
		send_request(v);
	endtask

	task automatic send_random(input int kind);
		logic [FIELD_BITS-1:0] v [12];
		int base [3];
		int reach, k;
		reach = 4;
		case ($urandom_range(0, 3))
			0: reach = 4;
			1: reach = 64;
			2: reach = 1500;
			default: reach = 20000;
		endcase
		for (int j = 0; j < 3; j++)
			base[j] = $urandom_range(0, 65535) - 32768;
		for (int i = 0; i < 12; i++)
			v[i] = 16'(base[i % 3] + $urandom_range(0, 2 * reach) - reach);
		if (kind == 0) begin
			for (int i = 0; i < 12; i++)
				v[i] = 16'($urandom);
		end else if (kind == 1) begin
			// Collinear or repeated vertices.
			k = $urandom_range(0, 4) - 2;
			for (int j = 0; j < 3; j++)
				v[9 + j] = v[3 + j] + 16'(k) * (v[6 + j] - v[3 + j]);
			if ($urandom_range(0, 1))
				for (int j = 0; j < 3; j++)
					v[6 + j] = v[3 + j];
		end
		send_request(v);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_points(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_points(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767);
		send_points(32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767, -32768,
			-32768, -32768, 32767);
		send_points(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, -32768,
			32767, 32767, 32767);
		send_points(-5, -5, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0);
		send_points(15, -2, 1, 0, 0, 0, 10, 0, 0, 0, 10, 0);
		send_points(5, -7, 3, 0, 0, 0, 10, 0, 0, 0, 10, 0);
		send_points(-1, 14, -3, 0, 0, 0, 10, 0, 0, 0, 10, 0);
		send_points(-6, 4, 2, 0, 0, 0, 10, 0, 0, 0, 10, 0);
		send_points(8, 8, 5, 0, 0, 0, 10, 0, 0, 0, 10, 0);
		send_points(2, 3, 7, 0, 0, 0, 10, 0, 0, 0, 10, 0);
		send_points(2, 3, -32768, 0, 0, 0, 32767, 0, 0, 0, 32767, 0);
		send_points(5, 5, 5, 1, 1, 1, 1, 1, 1, 9, 9, 9);
		send_points(4, 0, 0, 0, 0, 0, 2, 0, 0, 8, 0, 0);
		send_points(1, 2, 3, 7, 7, 7, 7, 7, 7, 7, 7, 7);
		send_points(3, 9, 1, -4, 0, 2, 6, 1, -3, 6, 1, -3);
		send_points(0, 0, 0, -32768, 0, 0, 32767, 0, 0, 0, -32768, 0);
		send_points(-1, -1, -1, 1, 2, 3, 3, 2, 1, 2, 2, 2);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n >= RANDOM_REQUESTS - 150)
				quiet_tail = 1'b1;
			case ($urandom_range(0, 9))
				0, 1: send_random(0);
				2: send_random(1);
				default: send_random(2);
			endcase
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("Sent %0d requests, checked %0d results in %0d cycles.", sent, checked,
			cycles);
		$display("Regions A B AB C AC BC face degenerate: %0d %0d %0d %0d %0d %0d %0d %0d",
			u_checker.region_hits[0], u_checker.region_hits[1], u_checker.region_hits[2],
			u_checker.region_hits[3], u_checker.region_hits[4], u_checker.region_hits[5],
			u_checker.region_hits[6], u_checker.region_hits[7]);
		if (failures == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ptds_pkg.sv
rtl/core/ptds_div.sv
rtl/core/point_triangle_distance_sq_unit.sv
bench/ptds_checker.sv
bench/tb_top.sv
